### design/codon_to_amino_translator_unit_assert.svh
// Assertion macros for the codon translator top level.
`ifndef CODON_TO_AMINO_TRANSLATOR_UNIT_ASSERT_SVH
`define CODON_TO_AMINO_TRANSLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CTAT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("codon translator check failed");
`define CTAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("codon translator check failed");
`else
`define CTAT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define CTAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/ctat_pkg.sv
// Types, genetic code tables and decode functions for the codon translator.
package ctat_pkg;

	localparam int TABLE_COUNT = 17;
	localparam int ROW_W = $clog2(TABLE_COUNT + 1);
	localparam logic [ROW_W-1:0] ROW_INVALID = ROW_W'(TABLE_COUNT);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ILLEGAL   = 2'd1,
		ST_BAD_TABLE = 2'd2
	} status_t;

	// Member sets use bit 0 for T, bit 1 for C, bit 2 for A, bit 3 for G.
	localparam logic [3:0] SET_T = 4'b0001;
	localparam logic [3:0] SET_C = 4'b0010;
	localparam logic [3:0] SET_A = 4'b0100;
	localparam logic [3:0] SET_G = 4'b1000;

	typedef struct packed {
		status_t          status;
		logic [ROW_W-1:0] row;
		logic [3:0]       group;
		logic [3:0]       set3;
	} dec_t;

	// One ROM word covers the four codons that share their first two bases.
	typedef struct packed {
		logic [3:0][7:0] amino;
		logic [3:0]      start;
	} rom_entry_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] amino;
		logic       start_mark;
		logic       stop_mark;
		logic [5:0] codon_index;
	} res_t;

	localparam logic [64*8-1:0] AMINO_ROM [TABLE_COUNT] = '{
		"FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSS**VVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCWWTTTTPPPPHHQQRRRRIIMMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSSSVVVVAAAADDEEGGGG",
		"FFLLSSSSYYQQCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCCWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CC*WLLLSPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSGGVVVVAAAADDEEGGGG",
		"FFLLSSSSYYY*CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG",
		"FFLLSSSSYY*QCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNNKSSSSVVVVAAAADDEEGGGG",
		"FFLLSS*SYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
		"FF*LSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG"
	};

	localparam logic [64*8-1:0] START_ROM [TABLE_COUNT] = '{
		"---M---------------M---------------M----------------------------",
		"--------------------------------MMMM---------------M------------",
		"-----------------------------------M----------------------------",
		"--MM---------------M------------MMMM---------------M------------",
		"---M----------------------------MMMM---------------M------------",
		"-----------------------------------M----------------------------",
		"-----------------------------------M----------------------------",
		"-----------------------------------M----------------------------",
		"---M---------------M------------MMMM---------------M------------",
		"-------------------M---------------M----------------------------",
		"-----------------------------------M----------------------------",
		"-----------------------------------M----------------------------",
		"-----------------------------------M----------------------------",
		"-----------------------------------M----------------------------",
		"-----------------------------------M----------------------------",
		"-----------------------------------M----------------------------",
		"--------------------------------M--M---------------M------------"
	};

	// Table number to ROM row; numbers without a table map to ROW_INVALID.
	localparam logic [ROW_W-1:0] TABLE_ROW [32] = '{
		ROW_INVALID, ROW_W'(0), ROW_W'(1), ROW_W'(2), ROW_W'(3), ROW_W'(4),
		ROW_W'(5), ROW_INVALID, ROW_INVALID, ROW_W'(6), ROW_W'(7), ROW_W'(8),
		ROW_W'(9), ROW_W'(10), ROW_W'(11), ROW_W'(12), ROW_W'(13), ROW_INVALID,
		ROW_INVALID, ROW_INVALID, ROW_INVALID, ROW_W'(14), ROW_W'(15),
		ROW_W'(16), ROW_INVALID, ROW_INVALID, ROW_INVALID, ROW_INVALID,
		ROW_INVALID, ROW_INVALID, ROW_INVALID, ROW_INVALID
	};

	function automatic logic [3:0] base_set(input logic [7:0] ch);
		logic [7:0] c;
		logic [3:0] s;
		c = ch;
		if (c >= "a" && c <= "z") begin
			c = c - 8'd32;
		end
		unique case (c)
			"T", "U": s = SET_T;
			"C":      s = SET_C;
			"A":      s = SET_A;
			"G":      s = SET_G;
			"N":      s = SET_A | SET_C | SET_G | SET_T;
			"S":      s = SET_C | SET_G;
			"Y":      s = SET_C | SET_T;
			"W":      s = SET_A | SET_T;
			"R":      s = SET_A | SET_G;
			"K":      s = SET_G | SET_T;
			"V":      s = SET_A | SET_C | SET_G;
			"B":      s = SET_C | SET_G | SET_T;
			"D":      s = SET_A | SET_G | SET_T;
			"H":      s = SET_A | SET_C | SET_T;
			"M":      s = SET_A | SET_C;
			default:  s = 4'b0000;
		endcase
		return s;
	endfunction

	// Smallest member in the order T, C, A, G.
	function automatic logic [1:0] smallest(input logic [3:0] s);
		logic [1:0] code;
		priority if (s[0]) code = 2'd0;
		else if (s[1])     code = 2'd1;
		else if (s[2])     code = 2'd2;
		else               code = 2'd3;
		return code;
	endfunction

	function automatic rom_entry_t rom_word(input logic [ROW_W-1:0] row,
			input logic [3:0] group);
		rom_entry_t e;
		int         pos;
		e = '0;
		if (row < ROW_INVALID) begin
			for (int k = 0; k < 4; k++) begin
				pos = 8 * (63 - (int'(group) * 4 + k));
				e.amino[k] = AMINO_ROM[row][pos +: 8];
				e.start[k] = (START_ROM[row][pos +: 8] == "M");
			end
		end
		return e;
	endfunction

endpackage

### design/ctat_decode.sv
// Base character decode, table number check and ROM group address.
module ctat_decode (
	input  logic [7:0]      base_first,
	input  logic [7:0]      base_second,
	input  logic [7:0]      base_third,
	input  logic [4:0]      code_table,
	output ctat_pkg::dec_t  dec
);

	logic [3:0]                 set0;
	logic [3:0]                 set1;
	logic [3:0]                 set2;
	logic [ctat_pkg::ROW_W-1:0] row;

	assign set0 = ctat_pkg::base_set(base_first);
	assign set1 = ctat_pkg::base_set(base_second);
	assign set2 = ctat_pkg::base_set(base_third);
	assign row  = ctat_pkg::TABLE_ROW[code_table];

	always_comb begin
		dec.row   = row;
		dec.group = {ctat_pkg::smallest(set0), ctat_pkg::smallest(set1)};
		dec.set3  = set2;
		priority if (row == ctat_pkg::ROW_INVALID) begin
			dec.status = ctat_pkg::ST_BAD_TABLE;
		end else if (set0 == 4'b0000 || set1 == 4'b0000 || set2 == 4'b0000) begin
			dec.status = ctat_pkg::ST_ILLEGAL;
		end else begin
			dec.status = ctat_pkg::ST_OK;
		end
	end

endmodule

### design/ctat_rom.sv
// Synchronous genetic code ROM, one word per table row and codon group.
module ctat_rom (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [ctat_pkg::ROW_W-1:0] row,
	input  logic [3:0]                 group,
	output ctat_pkg::rom_entry_t       rd_data
);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= ctat_pkg::rom_word(row, group);
		end
	end

endmodule

### design/ctat_resolve.sv
// Third base resolution: wildcard agreement, final codon index and flags.
module ctat_resolve (
	input  ctat_pkg::dec_t       dec,
	input  ctat_pkg::rom_entry_t ent,
	output ctat_pkg::res_t       res
);

	logic [1:0] small3;
	logic       single;
	logic       agree;
	logic [1:0] third;
	logic [7:0] aa;

	assign small3 = ctat_pkg::smallest(dec.set3);
	assign single = ((dec.set3 & (dec.set3 - 4'd1)) == 4'b0000);
	assign aa     = ent.amino[small3];

	always_comb begin
		agree = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (dec.set3[k] && ent.amino[k] != aa) begin
				agree = 1'b0;
			end
		end
	end

	// An agreeing wildcard reports the index with T as its third base.
	assign third = (single || !agree) ? small3 : 2'd0;

	always_comb begin
		res = '0;
		res.status = dec.status;
		if (dec.status == ctat_pkg::ST_OK) begin
			res.amino       = aa;
			res.start_mark  = ent.start[third];
			res.stop_mark   = (aa == "*");
			res.codon_index = {dec.group, third};
		end
	end

endmodule

### design/codon_to_amino_translator_unit.sv
// Codon translator top level: input decode, ROM stage and output register.
//
// Usage: the input channel takes one codon word per cycle while in_stall is
// low, three ASCII bases on base_first, base_second and base_third, with
// in_valid and in_stall. The output channel delivers amino, status,
// start_mark, stop_mark and codon_index with out_valid and out_stall.
// A word accepted at a clock edge is held in stage 1 with its ROM word, then
// moves on to the output register, where out_valid shows it; throughput is
// one word per cycle while out_stall is low. The synchronous genetic code ROM
// is read once per word at the input edge; resolution has one register stage.
// The configuration channel (cfg_valid, cfg_ready, code_table) selects the
// genetic code table; cfg_ready is always high and writes belong between
// streams, when no word is in flight.
// Reset clears the pipeline valid bits and sets the table number to 1.
// When the receiver stalls, the output word holds, the middle stage fills,
// and in_stall rises once both stages hold a word.
`include "codon_to_amino_translator_unit_assert.svh"

module codon_to_amino_translator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] base_first,
	input  logic [7:0] base_second,
	input  logic [7:0] base_third,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] amino,
	output logic [1:0] status,
	output logic       start_mark,
	output logic       stop_mark,
	output logic [5:0] codon_index,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] code_table
);

	logic [4:0]           code_table_q;
	ctat_pkg::dec_t       dec;
	ctat_pkg::dec_t       dec_s1;
	logic                 valid_s1;
	ctat_pkg::rom_entry_t rom_s1;
	ctat_pkg::res_t       res;
	ctat_pkg::res_t       res_s2;
	logic                 valid_s2;
	logic                 adv_s1;
	logic                 adv_s2;
	logic                 err_out;
	logic                 zero_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_table_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			code_table_q <= code_table;
		end
	end

	// Each stage moves when its successor is empty or moving.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	ctat_decode u_decode (
		.base_first  (base_first),
		.base_second (base_second),
		.base_third  (base_third),
		.code_table  (code_table_q),
		.dec         (dec)
	);

	ctat_rom u_rom (
		.clk     (clk),
		.rd_en   (adv_s1),
		.row     (dec.row),
		.group   (dec.group),
		.rd_data (rom_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dec_s1 <= dec;
		end
	end

	ctat_resolve u_resolve (
		.dec (dec_s1),
		.ent (rom_s1),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign amino       = res_s2.amino;
	assign status      = res_s2.status;
	assign start_mark  = res_s2.start_mark;
	assign stop_mark   = res_s2.stop_mark;
	assign codon_index = res_s2.codon_index;

	assign err_out  = out_valid && (res_s2.status != ctat_pkg::ST_OK);
	assign zero_out = (res_s2.amino == 8'd0) && (res_s2.codon_index == 6'd0) &&
		!res_s2.start_mark && !res_s2.stop_mark;

	`CTAT_ASSERT_IMPLY(a_err_zero, clk, arst_n, err_out, zero_out)
	`CTAT_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, valid_s1)
	`CTAT_ASSERT_IMPLY(a_full_stalls_in, clk, arst_n, valid_s2 && out_stall && valid_s1, in_stall)
	`CTAT_ASSERT_NEXT(a_s1_moves_to_s2, clk, arst_n, valid_s1 && adv_s2, valid_s2)

endmodule
